@@ design/gcdc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gcdc_pkg
// shared types, constants and calendar helper functions for the gregorian
// calendar day counter
// ----------------------------------------------------------------------------
package gcdc_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int WDAY_W   = 3;
    localparam int MOD400_W = 9;
    localparam int ZSUM_W   = 16;
    localparam int ZTERM_W  = 6;

    localparam logic [YEAR_W-1:0]  YEAR_MAX    = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_LAST  = 4'd12;
    localparam logic [YEAR_W-1:0]  RESET_YEAR  = 14'd2000;
    localparam logic [MONTH_W-1:0] RESET_MONTH = 4'd1;
    localparam logic [DAY_W-1:0]   RESET_DAY   = 5'd1;
    localparam logic [WDAY_W-1:0]  RESET_WDAY  = 3'd6;
    localparam logic [MOD400_W-1:0] RESET_MOD400 = MOD400_W'(RESET_YEAR % 400);
    localparam logic [WDAY_W-1:0]  WDAY_LAST   = 3'd6;
    localparam logic [MOD400_W-1:0] MOD400_LAST = 9'd399;

    // reciprocal for division by 100, exact for all 14-bit values
    localparam int Q100_MULT_W = 13;
    localparam logic [Q100_MULT_W-1:0] Q100_MULT = 13'd5243;
    localparam int Q100_SHIFT  = 19;
    localparam int PROD_W      = YEAR_W + Q100_MULT_W;
    localparam int Q100_W      = PROD_W - Q100_SHIFT;
    localparam int Q400_W      = Q100_W - 2;

    typedef enum logic {
        OP_ADVANCE = 1'b0,
        OP_LOAD    = 1'b1
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } item_t;

    // load item after both preparation stages
    typedef struct packed {
        op_t                 op;
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [MOD400_W-1:0] mod400;
        logic [ZSUM_W-1:0]   zsum;
        logic                ok;
    } prep_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [WDAY_W-1:0]  wday;
        logic               is_leap;
        logic [DAY_W-1:0]   month_length;
        logic               error;
    } result_t;

    typedef struct packed {
        logic s2;
        logic s3;
    } stage_en_t;

    function automatic logic leap_from_mod400(input logic [MOD400_W-1:0] r);
        return (r[1:0] == 2'd0) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
    endfunction

    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    // (13m + 8) / 5 for the shifted month 3..14
    function automatic logic [ZTERM_W-1:0] zeller_month_term(input logic [MONTH_W-1:0] m);
        logic [ZTERM_W-1:0] t;
        unique case (m)
            4'd3:    t = 6'd9;
            4'd4:    t = 6'd12;
            4'd5:    t = 6'd14;
            4'd6:    t = 6'd17;
            4'd7:    t = 6'd19;
            4'd8:    t = 6'd22;
            4'd9:    t = 6'd25;
            4'd10:   t = 6'd27;
            4'd11:   t = 6'd30;
            4'd12:   t = 6'd32;
            4'd13:   t = 6'd35;
            4'd14:   t = 6'd38;
            default: t = 6'd0;
        endcase
        return t;
    endfunction

    // mod 7 by folding octal digits, since 8 is 1 mod 7
    function automatic logic [WDAY_W-1:0] mod7(input logic [ZSUM_W-1:0] s);
        logic [5:0] s1;
        logic [3:0] s2;
        logic [3:0] s3;
        s1 = 6'(s[2:0]) + 6'(s[5:3]) + 6'(s[8:6]) + 6'(s[11:9])
           + 6'(s[14:12]) + 6'(s[15]);
        s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
        s3 = 4'(s2[3]) + 4'(s2[2:0]);
        return (s3 == 4'd7) ? 3'd0 : s3[2:0];
    endfunction

endpackage
`default_nettype wire

@@ design/gcdc_load_prep.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gcdc_load_prep
// two pipeline stages that check a load date and reduce its zeller sum,
// independent of the held date
// ----------------------------------------------------------------------------
module gcdc_load_prep
    import gcdc_pkg::*;
(
    input  wire logic      clk,
    input  wire item_t     item,
    input  wire stage_en_t en,
    output prep_t          prep
);

    typedef struct packed {
        op_t                op;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic               shifted;
        logic [YEAR_W-1:0]  yp;
        logic [Q100_W-1:0]  q100;
        logic [ZSUM_W-1:0]  part;
        logic               range_ok;
    } s2_t;

    s2_t   s2_reg, s2_next;
    prep_t s3_reg, s3_next;

    logic [MONTH_W-1:0]  mz;
    logic [PROD_W-1:0]   prod;
    logic [Q400_W-1:0]   q400;
    logic [YEAR_W-1:0]   r400_full;
    logic [MOD400_W-1:0] r400p;
    logic [MOD400_W-1:0] mod400;
    logic [DAY_W-1:0]    len;

    // january and february count as months 13 and 14 of the year before
    always_comb
    begin
        s2_next.op      = item.op;
        s2_next.year    = item.year;
        s2_next.month   = item.month;
        s2_next.day     = item.day;
        s2_next.shifted = item.month < 4'd3;
        s2_next.yp      = s2_next.shifted ? item.year - 14'd1 : item.year;
        mz              = s2_next.shifted ? item.month + 4'd12 : item.month;
        prod            = PROD_W'(s2_next.yp) * PROD_W'(Q100_MULT);
        s2_next.q100    = prod[PROD_W-1:Q100_SHIFT];
        s2_next.part    = ZSUM_W'(s2_next.yp) + ZSUM_W'(s2_next.yp >> 2)
                        + ZSUM_W'(zeller_month_term(mz)) + ZSUM_W'(item.day);
        s2_next.range_ok = (item.year != 14'd0) && (item.year <= YEAR_MAX)
                         && (item.month != 4'd0) && (item.month <= MONTH_LAST)
                         && (item.day != 5'd0);
    end

    always_comb
    begin
        q400      = s2_reg.q100[Q100_W-1:2];
        r400_full = s2_reg.yp - YEAR_W'(q400) * YEAR_W'(400);
        r400p     = r400_full[MOD400_W-1:0];
        // year mod 400 of the loaded year, not of the shifted one
        if (s2_reg.shifted)
        begin
            mod400 = (r400p == MOD400_LAST) ? '0 : r400p + 9'd1;
        end
        else
        begin
            mod400 = r400p;
        end
        len = month_days(s2_reg.month, leap_from_mod400(mod400));

        s3_next.op     = s2_reg.op;
        s3_next.year   = s2_reg.year;
        s3_next.month  = s2_reg.month;
        s3_next.day    = s2_reg.day;
        s3_next.mod400 = mod400;
        s3_next.zsum   = s2_reg.part - ZSUM_W'(s2_reg.q100) + ZSUM_W'(q400);
        s3_next.ok     = s2_reg.range_ok && (s2_reg.day <= len);
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            s2_reg <= s2_next;
        end
        if (en.s3)
        begin
            s3_reg <= s3_next;
        end
    end

    assign prep = s3_reg;

endmodule
`default_nettype wire

@@ design/gcdc_date_update.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gcdc_date_update
// held date and weekday: applies one advance or load per transaction and
// forms its result
// ----------------------------------------------------------------------------
module gcdc_date_update
    import gcdc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  fire,
    input  wire prep_t prep,
    output result_t    result
);

    logic [YEAR_W-1:0]   year_reg, year_next;
    logic [MONTH_W-1:0]  month_reg, month_next;
    logic [DAY_W-1:0]    day_reg, day_next;
    logic [WDAY_W-1:0]   weekday_reg, weekday_next;
    logic [MOD400_W-1:0] mod400_reg, mod400_next;

    logic [DAY_W-1:0]  cur_len;
    logic [WDAY_W-1:0] wday_inc;
    logic              err;
    logic              leap_next;

    assign cur_len  = month_days(month_reg, leap_from_mod400(mod400_reg));
    assign wday_inc = (weekday_reg == WDAY_LAST) ? '0 : weekday_reg + 3'd1;

    always_comb
    begin
        year_next    = year_reg;
        month_next   = month_reg;
        day_next     = day_reg;
        weekday_next = weekday_reg;
        mod400_next  = mod400_reg;
        err          = 1'b0;
        unique case (prep.op)
            OP_LOAD:
            begin
                if (prep.ok)
                begin
                    year_next    = prep.year;
                    month_next   = prep.month;
                    day_next     = prep.day;
                    mod400_next  = prep.mod400;
                    weekday_next = mod7(prep.zsum);
                end
                else
                begin
                    err = 1'b1;
                end
            end
            OP_ADVANCE:
            begin
                priority if (day_reg != cur_len)
                begin
                    day_next     = day_reg + 5'd1;
                    weekday_next = wday_inc;
                end
                else if (month_reg < MONTH_LAST)
                begin
                    day_next     = 5'd1;
                    month_next   = month_reg + 4'd1;
                    weekday_next = wday_inc;
                end
                else if (year_reg < YEAR_MAX)
                begin
                    day_next     = 5'd1;
                    month_next   = 4'd1;
                    year_next    = year_reg + 14'd1;
                    mod400_next  = (mod400_reg == MOD400_LAST) ? '0 : mod400_reg + 9'd1;
                    weekday_next = wday_inc;
                end
                else
                begin
                    // past the last representable day
                    err = 1'b1;
                end
            end
        endcase
    end

    assign leap_next           = leap_from_mod400(mod400_next);
    assign result.year         = year_next;
    assign result.month        = month_next;
    assign result.day          = day_next;
    assign result.wday         = weekday_next;
    assign result.is_leap      = leap_next;
    assign result.month_length = month_days(month_next, leap_next);
    assign result.error        = err;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_reg    <= RESET_YEAR;
            month_reg   <= RESET_MONTH;
            day_reg     <= RESET_DAY;
            weekday_reg <= RESET_WDAY;
            mod400_reg  <= RESET_MOD400;
        end
        else if (fire)
        begin
            year_reg    <= year_next;
            month_reg   <= month_next;
            day_reg     <= day_next;
            weekday_reg <= weekday_next;
            mod400_reg  <= mod400_next;
        end
    end

    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        (month_reg != 4'd0) && (month_reg <= MONTH_LAST))
        else $error("month out of range");

    a_day_range: assert property (@(posedge clk) disable iff (!rst_n)
        (day_reg != 5'd0) && (day_reg <= cur_len))
        else $error("day beyond month length");

    a_wday_range: assert property (@(posedge clk) disable iff (!rst_n)
        weekday_reg <= WDAY_LAST)
        else $error("weekday out of range");

    a_error_keeps_date: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && result.error) |=> ($stable(year_reg) && $stable(month_reg)
                                    && $stable(day_reg) && $stable(weekday_reg)))
        else $error("rejected transaction changed the date");

endmodule
`default_nettype wire

@@ design/gcdc_out_buffer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gcdc_out_buffer
// result register with one skid entry; its ready depends on registers only
// ----------------------------------------------------------------------------
module gcdc_out_buffer
    import gcdc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_data,
    output logic         ready,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_data
);

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    pop;

    assign pop = main_valid_reg && out_ready;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_next       = push_data;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign ready     = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

endmodule
`default_nettype wire

@@ design/gregorian_calendar_day_counter_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gregorian_calendar_day_counter_core
// gregorian date and weekday counter: advances one day or loads a date
// (weekday by zeller's congruence), one result per transaction
//
//   channel | signals                                        | direction
//   --------+------------------------------------------------+----------
//   in      | in_valid, in_ready, op, load_year, load_month, | sink
//           | load_day                                       |
//   out     | out_valid, out_ready, cur_year, cur_month,     | source
//           | cur_day, day_of_week, is_leap, month_length,   |
//           | error                                          |
//
// one transaction per cycle while out_ready holds; an input passes through the
// input register and two load preparation stages, then the date update writes
// its result to the result register
// reset gives 2000-01-01, a saturday, with all stages empty
// a stalled output fills the skid entry and then the empty stages in turn;
// in_ready comes from registers only
// ----------------------------------------------------------------------------
module gregorian_calendar_day_counter_core
    import gcdc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               op,
    input  wire logic [YEAR_W-1:0]  load_year,
    input  wire logic [MONTH_W-1:0] load_month,
    input  wire logic [DAY_W-1:0]   load_day,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [YEAR_W-1:0]       cur_year,
    output logic [MONTH_W-1:0]      cur_month,
    output logic [DAY_W-1:0]        cur_day,
    output logic [WDAY_W-1:0]       day_of_week,
    output logic                    is_leap,
    output logic [DAY_W-1:0]        month_length,
    output logic                    error
);

    logic      v1_reg, v2_reg, v3_reg;
    item_t     item_reg;
    stage_en_t en;
    prep_t     prep;
    result_t   result;
    result_t   out_data;
    logic      buf_ready;
    logic      fire;
    logic      r2, r3;

    // ready runs back from the skid flag so bubbles close up
    assign r3       = !v3_reg || buf_ready;
    assign r2       = !v2_reg || r3;
    assign in_ready = !v1_reg || r2;
    assign fire     = v3_reg && buf_ready;
    assign en.s2    = v1_reg && r2;
    assign en.s3    = v2_reg && r3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                v1_reg <= in_valid;
            end
            if (r2)
            begin
                v2_reg <= v1_reg;
            end
            if (r3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.op    <= op_t'(op);
            item_reg.year  <= load_year;
            item_reg.month <= load_month;
            item_reg.day   <= load_day;
        end
    end

    gcdc_load_prep u_load_prep (
        .clk  (clk),
        .item (item_reg),
        .en   (en),
        .prep (prep)
    );

    gcdc_date_update u_date_update (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .prep   (prep),
        .result (result)
    );

    gcdc_out_buffer u_out_buffer (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fire),
        .push_data (result),
        .ready     (buf_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign cur_year     = out_data.year;
    assign cur_month    = out_data.month;
    assign cur_day      = out_data.day;
    assign day_of_week  = out_data.wday;
    assign is_leap      = out_data.is_leap;
    assign month_length = out_data.month_length;
    assign error        = out_data.error;

endmodule
`default_nettype wire

@@ verif/gregorian_calendar_day_counter_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gregorian_calendar_day_counter_core_test
// self-checking bench for the calendar day counter: directed loads, rejected
// loads and roll-overs, then random load and advance sequences under random
// flow control on both channels, every result checked against a date predictor
// ----------------------------------------------------------------------------
module gregorian_calendar_day_counter_core_test;
    import gcdc_pkg::*;

    localparam int RANDOM_ITEMS = 1126;
    localparam int IDLE_LIMIT   = 2000;
    localparam int TAIL_CYCLES  = 10;

    localparam logic [YEAR_W-1:0]  START_YEAR  = 14'd2000;
    localparam logic [MONTH_W-1:0] START_MONTH = 4'd1;
    localparam logic [DAY_W-1:0]   START_DAY   = 5'd1;
    localparam logic [WDAY_W-1:0]  SATURDAY    = 3'd6;
    localparam logic [MONTH_W-1:0] DECEMBER    = 4'd12;
    localparam logic [YEAR_W-1:0]  LAST_YEAR   = 14'd9999;

    // receiver stall patterns
    localparam int RDY_ALWAYS   = 0;
    localparam int RDY_MOSTLY   = 1;
    localparam int RDY_SPARSE   = 2;
    localparam int RDY_PERIODIC = 3;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic               in_ready;
    op_t                op         = OP_ADVANCE;
    logic [YEAR_W-1:0]  load_year  = '0;
    logic [MONTH_W-1:0] load_month = '0;
    logic [DAY_W-1:0]   load_day   = '0;
    logic               out_valid;
    logic               out_ready  = 1'b0;
    logic [YEAR_W-1:0]  cur_year;
    logic [MONTH_W-1:0] cur_month;
    logic [DAY_W-1:0]   cur_day;
    logic [WDAY_W-1:0]  day_of_week;
    logic               is_leap;
    logic [DAY_W-1:0]   month_length;
    logic               error;

    gregorian_calendar_day_counter_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .load_year    (load_year),
        .load_month   (load_month),
        .load_day     (load_day),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .cur_year     (cur_year),
        .cur_month    (cur_month),
        .cur_day      (cur_day),
        .day_of_week  (day_of_week),
        .is_leap      (is_leap),
        .month_length (month_length),
        .error        (error)
    );

    always #1 clk = ~clk;

    // predicted calendar state
    logic [YEAR_W-1:0]  cal_year  = START_YEAR;
    logic [MONTH_W-1:0] cal_month = START_MONTH;
    logic [DAY_W-1:0]   cal_day   = START_DAY;
    logic [WDAY_W-1:0]  cal_wday  = SATURDAY;

    result_t pending_dates[$];

    int mismatches      = 0;
    int idle_cycles     = 0;
    int items_sent      = 0;
    int loads_sent      = 0;
    int advances_sent   = 0;
    int rejects_seen    = 0;
    int year_rolls      = 0;
    int results_checked = 0;
    int burst_left      = 0;
    int rdy_mode        = RDY_ALWAYS;
    int rdy_left        = 0;
    int rdy_cycle       = 0;

    function automatic logic leap_year(input int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned days_in(input int unsigned y, input int unsigned m);
        int unsigned n;
        case (m)
            2:           n = leap_year(y) ? 29 : 28;
            4, 6, 9, 11: n = 30;
            default:     n = 31;
        endcase
        return n;
    endfunction

    // zeller's congruence with 0 as sunday; january and february belong to
    // the year before as months 13 and 14
    function automatic int unsigned weekday_of(input int unsigned y, input int unsigned m,
                                               input int unsigned d);
        if (m < 3)
        begin
            y = y - 1;
            m = m + 12;
        end
        return (y + y / 4 - y / 100 + y / 400 + (13 * m + 8) / 5 + d) % 7;
    endfunction

    task automatic predict_date_update(input op_t o, input int unsigned y,
                                       input int unsigned m, input int unsigned d);
        result_t r;
        logic    rejected;
        rejected = 1'b0;
        if (o == OP_LOAD)
        begin
            loads_sent++;
            if (y >= 1 && y <= LAST_YEAR && m >= 1 && m <= 12 && d >= 1 && d <= days_in(y, m))
            begin
                cal_year  = YEAR_W'(y);
                cal_month = MONTH_W'(m);
                cal_day   = DAY_W'(d);
                cal_wday  = WDAY_W'(weekday_of(y, m, d));
            end
            else
            begin
                rejected = 1'b1;
            end
        end
        else
        begin
            advances_sent++;
            if (cal_day != days_in(cal_year, cal_month))
            begin
                cal_day  = cal_day + 1'b1;
                cal_wday = (cal_wday == SATURDAY) ? '0 : cal_wday + 1'b1;
            end
            else if (cal_month < DECEMBER)
            begin
                cal_day   = START_DAY;
                cal_month = cal_month + 1'b1;
                cal_wday  = (cal_wday == SATURDAY) ? '0 : cal_wday + 1'b1;
            end
            else if (cal_year < LAST_YEAR)
            begin
                cal_day   = START_DAY;
                cal_month = START_MONTH;
                cal_year  = cal_year + 1'b1;
                cal_wday  = (cal_wday == SATURDAY) ? '0 : cal_wday + 1'b1;
                year_rolls++;
            end
            else
            begin
                rejected = 1'b1;
            end
        end
        if (rejected)
            rejects_seen++;
        r.year         = cal_year;
        r.month        = cal_month;
        r.day          = cal_day;
        r.wday         = cal_wday;
        r.is_leap      = leap_year(cal_year);
        r.month_length = DAY_W'(days_in(cal_year, cal_month));
        r.error        = rejected;
        pending_dates.push_back(r);
    endtask

    // sender bursts: before each burst a random gap, sometimes none
    task automatic send_date_item(input op_t o, input logic [YEAR_W-1:0] y,
                                  input logic [MONTH_W-1:0] m, input logic [DAY_W-1:0] d);
        int   gap;
        logic taken;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 12);
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid   <= 1'b1;
        op         <= o;
        load_year  <= y;
        load_month <= m;
        load_day   <= d;
        do
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        while (!taken);
        predict_date_update(o, y, m, d);
        items_sent++;
    endtask

    // the load fields are don't-care on an advance, so they carry noise
    task automatic send_advance();
        send_date_item(OP_ADVANCE, YEAR_W'($urandom_range(0, 16383)),
                       MONTH_W'($urandom_range(0, 15)), DAY_W'($urandom_range(0, 31)));
    endtask

    task automatic send_load(input int unsigned y, input int unsigned m, input int unsigned d);
        send_date_item(OP_LOAD, YEAR_W'(y), MONTH_W'(m), DAY_W'(d));
    endtask

    task automatic pause_until_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_dates.size() != 0);
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // outputs and ready are stable at the falling edge, so a transaction seen
    // here completes at the next rising edge
    always @(negedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (out_valid && out_ready)
            begin
                if (pending_dates.size() == 0)
                begin
                    $error("result %0d-%0d-%0d with no transaction pending",
                           cur_year, cur_month, cur_day);
                    mismatches++;
                end
                else
                begin
                    want = pending_dates.pop_front();
                    check_field("cur_year", want.year, cur_year);
                    check_field("cur_month", want.month, cur_month);
                    check_field("cur_day", want.day, cur_day);
                    check_field("day_of_week", want.wday, day_of_week);
                    check_field("is_leap", want.is_leap, is_leap);
                    check_field("month_length", want.month_length, month_length);
                    check_field("error", want.error, error);
                    results_checked++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        rdy_cycle++;
        if (rdy_left == 0)
        begin
            rdy_mode = $urandom_range(RDY_ALWAYS, RDY_PERIODIC);
            rdy_left = $urandom_range(20, 200);
        end
        rdy_left--;
        case (rdy_mode)
            RDY_ALWAYS: out_ready <= 1'b1;
            RDY_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
            RDY_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
            default:    out_ready <= ((rdy_cycle % 5) < 2);
        endcase
    end

    initial
    begin : watchdog
        while (idle_cycles < IDLE_LIMIT)
            @(negedge clk);
        $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("gregorian_calendar_day_counter_core test failed");
        $finish;
    end

    // first steps from the reset date, a saturday
    task automatic test_reset_date();
        send_advance();
        send_advance();
    endtask

    task automatic test_load_bounds();
        send_load(1, 1, 1);
        send_load(2000, 2, 29);
        send_load(9999, 12, 31);
        // advancing past the last representable day is refused
        send_advance();
        send_advance();
    endtask

    task automatic test_invalid_loads();
        send_load(0, 6, 15);
        send_load(16383, 15, 31);
        send_load(10000, 1, 1);
        send_load(2021, 0, 10);
        send_load(2021, 13, 10);
        send_load(2021, 7, 0);
        send_load(1900, 2, 29);
        send_load(2023, 4, 31);
        send_load(2024, 2, 30);
    endtask

    task automatic test_rollovers();
        send_load(2024, 2, 28);
        send_advance();
        send_advance();
        send_load(1900, 2, 28);
        send_advance();
        send_load(2023, 12, 31);
        send_advance();
        send_load(2023, 4, 30);
        send_advance();
    endtask

    // mostly valid loads just before a month end followed by advances, plus
    // long advance runs, rejected near-misses and raw noise
    task automatic test_random_sequences();
        int unsigned kind;
        int unsigned y;
        int unsigned m;
        int unsigned d;
        int unsigned len;
        int          n;
        int          first;
        logic        drained;
        first   = items_sent;
        drained = 1'b0;
        while (items_sent - first < RANDOM_ITEMS)
        begin
            if (!drained && items_sent - first >= RANDOM_ITEMS / 2)
            begin
                pause_until_drained();
                drained = 1'b1;
            end
            kind = $urandom_range(0, 99);
            case ($urandom_range(0, 3))
                0:       y = $urandom_range(1, 9999);
                1:       y = 100 * $urandom_range(1, 99);
                2:       y = 4 * $urandom_range(1, 2499);
                default: y = 9999 - $urandom_range(0, 1);
            endcase
            case ($urandom_range(0, 2))
                0:       m = 2;
                1:       m = 12;
                default: m = $urandom_range(1, 12);
            endcase
            len = days_in(y, m);
            if (kind < 60)
            begin
                send_load(y, m, len - $urandom_range(0, 3));
                n = $urandom_range(1, 6);
                repeat (n) send_advance();
            end
            else if (kind < 75)
            begin
                n = $urandom_range(10, 60);
                repeat (n) send_advance();
            end
            else if (kind < 90)
            begin
                send_load($urandom_range(0, 16383), $urandom_range(0, 15), $urandom_range(0, 31));
            end
            else
            begin
                // a day past the month end or zero, a month past december, or year zero
                if (len < 31 && $urandom_range(0, 1) == 0)
                    d = $urandom_range(len + 1, 31);
                else
                    d = 0;
                case ($urandom_range(0, 2))
                    0:       send_load(y, m, d);
                    1:       send_load(y, 13 + $urandom_range(0, 2), $urandom_range(1, 28));
                    default: send_load(0, m, $urandom_range(1, 28));
                endcase
            end
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_date();
        test_load_bounds();
        test_invalid_loads();
        test_rollovers();
        test_random_sequences();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_dates.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("covered %0d loads and %0d advances, %0d of them refused, %0d year roll-overs",
                 loads_sent, advances_sent, rejects_seen, year_rolls);
        $display("%0d results checked under random stalls on both channels", results_checked);
        if (mismatches == 0)
            $display("gregorian_calendar_day_counter_core test passed");
        else
            $display("gregorian_calendar_day_counter_core test failed");
        $finish;
    end

endmodule
